// File: rtl/itrt_pkg.sv
// Shared types, constants and helpers for the integer to radix text converter.
package itrt_pkg;

	localparam int NUM_BITS_DEF    = 32;
	localparam int VALUE_W         = 32;
	localparam int RADIX_W         = 5;
	localparam int FLAGS_W         = 2;
	localparam int CHAR_W          = 7;
	localparam int DIGIT_W         = 4;
	localparam int STEPS_PER_CYCLE = 8;
	localparam int QUEUE_DEPTH     = 2;

	localparam int FLAG_UNSIGNED = 0;
	localparam int FLAG_LOWER    = 1;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

	localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_F = 7'h46;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_F = 7'h66;

	// Classified item as it leaves the front queue (magnitude travels alongside)
	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               neg;
		logic               lower;
	} item_ctl_t;

	// One character offered by the back part
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} emit_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_PRE,
		BK_SIGN,
		BK_EMIT
	} bk_state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic lower);
		logic [CHAR_W-1:0] base_a;
		base_a = lower ? CH_LOWER_A : CH_UPPER_A;
		if (d < DIGIT_TEN) begin
			return CH_ZERO + CHAR_W'(d);
		end else begin
			return base_a + CHAR_W'(d - DIGIT_TEN);
		end
	endfunction

endpackage

// File: rtl/itrt_front.sv
// Front part: accepts items, clamps radix, takes sign and magnitude, queues them.
module itrt_front import itrt_pkg::*; #(
	parameter int NUM_BITS = NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [VALUE_W-1:0]  value_bits,
	input  logic [RADIX_W-1:0]  radix,
	input  logic [FLAGS_W-1:0]  format_flags,
	input  logic                push,
	output logic                full,
	output logic                q_valid,
	output logic [NUM_BITS-1:0] q_mag,
	output item_ctl_t           q_ctl,
	input  logic                q_pop
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [NUM_BITS-1:0] mag_q [QUEUE_DEPTH];
	item_ctl_t           ctl_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	logic [NUM_BITS-1:0] word;
	logic [NUM_BITS-1:0] mag_c;
	item_ctl_t           ctl_c;
	logic                push_ok;
	logic                pop_ok;

	always_comb begin
		word = NUM_BITS'(value_bits);
		ctl_c.neg = !format_flags[FLAG_UNSIGNED] && word[NUM_BITS-1];
		ctl_c.lower = format_flags[FLAG_LOWER];
		if (radix < RADIX_MIN) begin
			ctl_c.radix = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			ctl_c.radix = RADIX_MAX;
		end else begin
			ctl_c.radix = radix;
		end
		// most negative value negates to itself, read as unsigned it is right
		mag_c = ctl_c.neg ? (NUM_BITS'(0) - word) : word;
	end

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign push_ok = push && !full;
	assign pop_ok  = q_pop && q_valid;
	assign q_mag   = mag_q[rd_ptr_q];
	assign q_ctl   = ctl_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mag_q[wr_ptr_q] <= mag_c;
			ctl_q[wr_ptr_q] <= ctl_c;
		end
	end

endmodule

// File: rtl/itrt_back.sv
// Back part: iterative divider filling the digit memory, then character sequencer.
module itrt_back import itrt_pkg::*; #(
	parameter int NUM_BITS = NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [NUM_BITS-1:0] q_mag,
	input  item_ctl_t           q_ctl,
	output logic                q_pop,
	output emit_t               emit,
	input  logic                emit_ready,
	output logic                idle
);

	localparam int PASSES = (NUM_BITS + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE;
	localparam int PW     = PASSES * STEPS_PER_CYCLE;
	localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
	localparam int IDX_W  = $clog2(NUM_BITS);
	localparam int CNT_W  = $clog2(NUM_BITS + 1);

	bk_state_t state_q, state_d;

	logic [DIGIT_W-1:0]  digit_mem [NUM_BITS];
	logic [PW-1:0]       dvd_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [PASS_W-1:0]   pass_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [DIGIT_W-1:0]  rd_q;
	logic [RADIX_W-1:0]  radix_q;
	logic                neg_q;
	logic                lower_q;

	logic [DIGIT_W:0]           part;
	logic [DIGIT_W-1:0]         rem_w;
	logic [STEPS_PER_CYCLE-1:0] qbits;
	logic [PW-1:0]              dvd_nx;
	logic                       last_pass;
	logic                       digits_done;
	logic                       mem_we;
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic                       load;

	// restoring division, STEPS_PER_CYCLE quotient bits a cycle, remainder stays narrow
	always_comb begin
		rem_w = rem_q;
		qbits = '0;
		part  = '0;
		for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
			part = {rem_w, dvd_q[PW-1-s]};
			if (part >= radix_q) begin
				part = part - radix_q;
				qbits[STEPS_PER_CYCLE-1-s] = 1'b1;
			end
			rem_w = part[DIGIT_W-1:0];
		end
		dvd_nx      = (dvd_q << STEPS_PER_CYCLE) | PW'(qbits);
		last_pass   = (pass_q == PASS_W'(PASSES - 1));
		digits_done = (dvd_nx == '0) || (cnt_q == CNT_W'(NUM_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		load    = 1'b0;
		mem_we  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		emit    = '0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					load    = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (last_pass) begin
					mem_we = 1'b1;
					if (digits_done) begin
						state_d = BK_PRE;
					end
				end
			end
			BK_PRE: begin
				// fetch the most significant digit ahead of the sign
				rd_en   = 1'b1;
				state_d = neg_q ? BK_SIGN : BK_EMIT;
			end
			BK_SIGN: begin
				emit.valid = 1'b1;
				emit.ch    = CH_MINUS;
				emit.last  = 1'b0;
				if (emit_ready) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				emit.valid = 1'b1;
				emit.ch    = digit_char(rd_q, lower_q);
				emit.last  = (idx_q == '0);
				if (emit_ready) begin
					if (idx_q == '0) begin
						state_d = BK_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (load) begin
			pass_q <= '0;
			cnt_q  <= '0;
		end else if (state_q == BK_DIV) begin
			if (last_pass) begin
				pass_q <= '0;
				cnt_q  <= cnt_q + 1'b1;
				idx_q  <= cnt_q[IDX_W-1:0];
			end else begin
				pass_q <= pass_q + 1'b1;
			end
		end else if (state_q == BK_EMIT && emit_ready && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q   <= PW'(q_mag);
			rem_q   <= '0;
			radix_q <= q_ctl.radix;
			neg_q   <= q_ctl.neg;
			lower_q <= q_ctl.lower;
		end else if (state_q == BK_DIV) begin
			dvd_q <= dvd_nx;
			rem_q <= last_pass ? '0 : rem_w;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[IDX_W-1:0]] <= rem_w;
		end
		if (rd_en) begin
			rd_q <= digit_mem[rd_addr];
		end
	end

	assign idle = (state_q == BK_IDLE);

endmodule

// File: rtl/integer_to_radix_text_core.sv
// Integer to ASCII text converter in radix 2 to 16, one character per transaction.
// An item is a value word, a radix (clamped into 2..16) and two flags (unsigned, lowercase).
// Its text comes out most significant character first, with a leading minus sign for a
// negative signed value, and last_char marks the final character. A two-entry front queue
// takes new items while the back part works. The back part loads an item, then runs its
// divider over the whole word for each digit (8 quotient bits a cycle) and writes each digit
// to the digit memory, fetches the top digit from the digit memory, and then offers the
// characters one after another, holding while pop does not keep up.
module integer_to_radix_text_core import itrt_pkg::*; #(
	parameter int NUM_BITS = NUM_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value_bits,
	input  logic [RADIX_W-1:0] radix,
	input  logic [FLAGS_W-1:0] format_flags,
	input  logic               push,
	output logic               full,
	output logic [CHAR_W-1:0]  text_char,
	output logic               last_char,
	output logic               empty,
	input  logic               pop
);

	logic                q_valid;
	logic [NUM_BITS-1:0] q_mag;
	item_ctl_t           q_ctl;
	logic                q_pop;
	emit_t               emit;
	logic                emit_ready;
	logic                bk_idle;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;

	itrt_front #(.NUM_BITS(NUM_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.value_bits   (value_bits),
		.radix        (radix),
		.format_flags (format_flags),
		.push         (push),
		.full         (full),
		.q_valid      (q_valid),
		.q_mag        (q_mag),
		.q_ctl        (q_ctl),
		.q_pop        (q_pop)
	);

	itrt_back #(.NUM_BITS(NUM_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_mag      (q_mag),
		.q_ctl      (q_ctl),
		.q_pop      (q_pop),
		.emit       (emit),
		.emit_ready (emit_ready),
		.idle       (bk_idle)
	);

	// output register: refill in the same cycle the held character is popped
	assign emit_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && emit_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			char_q <= emit.ch;
			last_q <= emit.last;
		end
	end

	assign empty     = !out_valid_q;
	assign text_char = char_q;
	assign last_char = last_q;

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && text_char == CH_MINUS) |-> !last_char)
		else $error("minus sign marked as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (text_char == CH_MINUS
			|| (text_char >= CH_ZERO && text_char <= CH_NINE)
			|| (text_char >= CH_UPPER_A && text_char <= CH_UPPER_F)
			|| (text_char >= CH_LOWER_A && text_char <= CH_LOWER_F)))
		else $error("character outside the digit set");

	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && bk_idle) |=> !bk_idle)
		else $error("queued item not taken by idle back part");

endmodule
